@@ hw/rtl/nir_pkg.sv @@
// ----------------------------------------------------------------------------
// nir_pkg
// Shared types and constants of the NEC infrared frame receiver: event codes,
// register indexes and reset values, payload structs and the window compare.
// ----------------------------------------------------------------------------
package nir_pkg;

    // Widths of the fields.
    localparam int unsigned TICK_W  = 11;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned FRAME_BITS = 32;

    // Event codes carried by the cmd field.
    localparam logic [CMD_W-1:0] EV_EDGE    = 2'd0;
    localparam logic [CMD_W-1:0] EV_TIMEOUT = 2'd1;
    localparam logic [CMD_W-1:0] EV_READ    = 2'd2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_HIGH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ONE_LOW     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd5;

    // Reset values of the timing windows, in ticks.
    localparam logic [TICK_W-1:0] RST_LEADER_LOW  = 11'd190;
    localparam logic [TICK_W-1:0] RST_LEADER_HIGH = 11'd230;
    localparam logic [TICK_W-1:0] RST_ONE_LOW     = 11'd30;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH    = 11'd40;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW    = 11'd14;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH   = 11'd22;

    // Timing windows as held by the register block.
    typedef struct packed {
        logic [TICK_W-1:0] leader_low;
        logic [TICK_W-1:0] leader_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] zero_high;
    } t_cfg;

    // One input event.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TICK_W-1:0] interval;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [BYTE_W-1:0]  command;
        logic               command_ok;
        logic [BYTE_W-1:0]  address_low;
        logic [BYTE_W-1:0]  address_high;
        logic               frame_ready;
        logic [INDEX_W-1:0] bits_received;
    } t_out_item;

    // True when a tick count lies strictly between both bounds.
    function automatic logic in_window(
        input logic [TICK_W-1:0] v,
        input logic [TICK_W-1:0] lo,
        input logic [TICK_W-1:0] hi
    );
        return (v > lo) && (v < hi);
    endfunction

endpackage

@@ hw/rtl/nec_ir_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_receiver
// Decodes an NEC infrared frame from timed falling-edge events.
// ----------------------------------------------------------------------------
// Usage: events enter on the input channel (i_in_valid, o_in_stall,
// i_in_data): a falling edge with its tick interval, a timer overflow or a
// read request. Every event yields exactly one result transaction on the
// output channel (o_out_valid, i_out_stall, o_out_data) carrying the checked
// command, the address bytes, the ready flag and the bit count.
// The timing windows are set through the write port (i_cfg_we, i_cfg_index,
// i_cfg_data) while no event is in flight.
// An accepted event waits in the input register, then the decode and state
// update land in the result register together. One event is accepted every
// cycle while the receiver does not stall; the only loop is the registered
// state update feeding the next event.
// Reset clears the frame state, loads the default windows and empties both
// registers. While the receiver stalls, the result is held, one more event
// may wait in the input register, and then o_in_stall is raised.
// ----------------------------------------------------------------------------
module nec_ir_frame_receiver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Event channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  nir_pkg::t_in_item                  i_in_data,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output nir_pkg::t_out_item                 o_out_data,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [nir_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [nir_pkg::TICK_W-1:0]         i_cfg_data
);

    nir_pkg::t_cfg      cfg;

    // Pipeline registers.
    logic               r_in_valid;
    nir_pkg::t_in_item  r_in;
    logic               r_out_valid;
    nir_pkg::t_out_item r_out;

    // Frame state.
    logic                              r_first_edge, n_first_edge;
    logic                              r_receiving,  n_receiving;
    logic                              r_ready,      n_ready;
    logic [nir_pkg::INDEX_W-1:0]       r_bit_index,  n_bit_index;
    logic [nir_pkg::FRAME_BITS-1:0]    r_frame,      n_frame;
    nir_pkg::t_out_item                n_out;

    logic out_load;
    logic in_load;

    // Timing window registers.
    nir_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Handshake: the result register loads when empty or being taken.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = r_in_valid && !out_load;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Event decode and next frame state.
    always_comb begin
        logic [nir_pkg::TICK_W-1:0]  iv;
        logic [nir_pkg::INDEX_W-1:0] idx_a;
        logic [nir_pkg::INDEX_W-1:0] idx_b;
        logic                        active;
        logic                        one_hit;
        logic                        zero_hit;

        n_first_edge = r_first_edge;
        n_receiving  = r_receiving;
        n_ready      = r_ready;
        n_bit_index  = r_bit_index;
        n_frame      = r_frame;
        n_out.command    = '0;
        n_out.command_ok = 1'b0;

        iv       = r_first_edge ? '0 : r_in.interval;
        idx_a    = r_bit_index;
        idx_b    = r_bit_index;
        active   = 1'b0;
        one_hit  = 1'b0;
        zero_hit = 1'b0;

        case (r_in.cmd)
            nir_pkg::EV_EDGE: begin
                n_first_edge = 1'b0;
                // A full frame followed by another edge ends reception.
                if (r_bit_index > 6'd31) begin
                    idx_a       = '0;
                    n_receiving = 1'b0;
                    n_ready     = 1'b1;
                end
                if (nir_pkg::in_window(iv, cfg.leader_low, cfg.leader_high)) begin
                    n_receiving = 1'b1;
                end
                active   = n_receiving && !n_ready;
                one_hit  = active && nir_pkg::in_window(iv, cfg.one_low, cfg.one_high);
                zero_hit = active && nir_pkg::in_window(iv, cfg.zero_low, cfg.zero_high);
                // A one is stored first, then a zero at the following index.
                if (one_hit && !idx_a[5]) begin
                    n_frame[idx_a[4:0]] = 1'b1;
                end
                idx_b = idx_a + {5'd0, one_hit};
                if (zero_hit && !idx_b[5]) begin
                    n_frame[idx_b[4:0]] = 1'b0;
                end
                n_bit_index = idx_b + {5'd0, zero_hit};
            end
            nir_pkg::EV_TIMEOUT: begin
                n_first_edge = 1'b1;
                n_receiving  = 1'b0;
                if (r_bit_index[5]) begin
                    n_ready = 1'b1;
                end
                n_bit_index = '0;
            end
            nir_pkg::EV_READ: begin
                if (r_ready) begin
                    n_ready         = 1'b0;
                    n_frame[31:16]  = '0;
                    if (r_frame[23:16] == ~r_frame[31:24]) begin
                        n_out.command    = r_frame[23:16];
                        n_out.command_ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        n_out.address_low   = n_frame[7:0];
        n_out.address_high  = n_frame[15:8];
        n_out.frame_ready   = n_ready;
        n_out.bits_received = n_bit_index;
    end

    // State and result registers update together with each event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_edge <= 1'b1;
            r_receiving  <= 1'b0;
            r_ready      <= 1'b0;
            r_bit_index  <= '0;
            r_frame      <= '0;
            r_out_valid  <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_first_edge <= n_first_edge;
                r_receiving  <= n_receiving;
                r_ready      <= n_ready;
                r_bit_index  <= n_bit_index;
                r_frame      <= n_frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/nir_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// nir_cfg_regs
// Timing window registers of the receiver, written through a plain write port.
// ----------------------------------------------------------------------------
module nir_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nir_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [nir_pkg::TICK_W-1:0]         i_cfg_data,
    output nir_pkg::t_cfg                      o_cfg
);

    nir_pkg::t_cfg r_cfg;

    // Register write decode; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_low  <= nir_pkg::RST_LEADER_LOW;
            r_cfg.leader_high <= nir_pkg::RST_LEADER_HIGH;
            r_cfg.one_low     <= nir_pkg::RST_ONE_LOW;
            r_cfg.one_high    <= nir_pkg::RST_ONE_HIGH;
            r_cfg.zero_low    <= nir_pkg::RST_ZERO_LOW;
            r_cfg.zero_high   <= nir_pkg::RST_ZERO_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nir_pkg::REG_LEADER_LOW:  r_cfg.leader_low  <= i_cfg_data;
                nir_pkg::REG_LEADER_HIGH: r_cfg.leader_high <= i_cfg_data;
                nir_pkg::REG_ONE_LOW:     r_cfg.one_low     <= i_cfg_data;
                nir_pkg::REG_ONE_HIGH:    r_cfg.one_high    <= i_cfg_data;
                nir_pkg::REG_ZERO_LOW:    r_cfg.zero_low    <= i_cfg_data;
                nir_pkg::REG_ZERO_HIGH:   r_cfg.zero_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ tb/sv/nec_ir_frame_receiver_tb.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_receiver_tb
// Self-checking testbench for the NEC infrared frame receiver. Event
// transactions are driven with random idling on both channels. A behavioural
// decoder predicts every result transaction, and each one that arrives is
// compared field by field with the oldest prediction. The run covers the
// default timing windows, overlapping windows and the extreme window settings,
// using directed events first, then random frames, broken frames and noise.
// ----------------------------------------------------------------------------
module nec_ir_frame_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Event code that the block has to ignore.
    localparam logic [nir_pkg::CMD_W-1:0] EV_UNUSED = 2'd3;

    // Byte slots of a frame, in order of arrival.
    localparam int unsigned SLOT_ADDR_LO = 0;
    localparam int unsigned SLOT_ADDR_HI = 1;
    localparam int unsigned SLOT_CMD     = 2;
    localparam int unsigned SLOT_CMD_INV = 3;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned MAX_SEND_GAP = 40;

    // Block ports.
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    nir_pkg::t_in_item             i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    nir_pkg::t_out_item            o_out_data;
    logic                          i_cfg_we    = 1'b0;
    logic [nir_pkg::REG_IDX_W-1:0] i_cfg_index = '0;
    logic [nir_pkg::TICK_W-1:0]    i_cfg_data  = '0;

    // Decoder state as predicted by the testbench.
    nir_pkg::t_cfg               win = '{nir_pkg::RST_LEADER_LOW, nir_pkg::RST_LEADER_HIGH,
                                         nir_pkg::RST_ONE_LOW, nir_pkg::RST_ONE_HIGH,
                                         nir_pkg::RST_ZERO_LOW, nir_pkg::RST_ZERO_HIGH};
    logic                        m_first = 1'b1;
    logic                        m_recv  = 1'b0;
    logic                        m_ready = 1'b0;
    logic [nir_pkg::INDEX_W-1:0] m_bits  = '0;
    logic [nir_pkg::BYTE_W-1:0]  m_frame [4] = '{default: '0};

    // Scoreboard and run control.
    nir_pkg::t_out_item pending_results [$];
    nir_pkg::t_out_item want;
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;

    nec_ir_frame_receiver uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // A tick count strictly inside both bounds; an empty window matches nothing.
    function automatic logic tick_between(input logic [nir_pkg::TICK_W-1:0] v,
                                          input logic [nir_pkg::TICK_W-1:0] lo,
                                          input logic [nir_pkg::TICK_W-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    // Stores one bit LSB-first; bits past the frame only move the index on.
    function automatic void push_bit(input logic one);
        if (m_bits < nir_pkg::FRAME_BITS) begin
            m_frame[m_bits[4:3]][m_bits[2:0]] = one;
        end
        if (m_bits != '1) begin
            m_bits++;
        end
    endfunction

    // Applies one event to the predicted state and returns the expected result.
    function automatic nir_pkg::t_out_item decode_event(input nir_pkg::t_in_item ev);
        nir_pkg::t_out_item         res;
        logic [nir_pkg::TICK_W-1:0] iv;
        res = '0;
        iv  = ev.interval;
        case (ev.cmd)
            nir_pkg::EV_EDGE: begin
                // The first edge after idle has no previous edge to time from.
                if (m_first) begin
                    iv      = '0;
                    m_first = 1'b0;
                end
                if (m_bits >= nir_pkg::FRAME_BITS) begin
                    m_bits  = '0;
                    m_recv  = 1'b0;
                    m_ready = 1'b1;
                end
                if (tick_between(iv, win.leader_low, win.leader_high)) begin
                    m_recv = 1'b1;
                end
                // Both windows are tried in turn, so one edge may give two bits.
                if (m_recv && !m_ready) begin
                    if (tick_between(iv, win.one_low, win.one_high)) begin
                        push_bit(1'b1);
                    end
                    if (tick_between(iv, win.zero_low, win.zero_high)) begin
                        push_bit(1'b0);
                    end
                end
            end
            nir_pkg::EV_TIMEOUT: begin
                m_first = 1'b1;
                m_recv  = 1'b0;
                if (m_bits >= nir_pkg::FRAME_BITS) begin
                    m_ready = 1'b1;
                end
                m_bits = '0;
            end
            nir_pkg::EV_READ: begin
                if (m_ready) begin
                    m_ready = 1'b0;
                    if (m_frame[SLOT_CMD] == ~m_frame[SLOT_CMD_INV]) begin
                        res.command    = m_frame[SLOT_CMD];
                        res.command_ok = 1'b1;
                    end
                    m_frame[SLOT_CMD]     = '0;
                    m_frame[SLOT_CMD_INV] = '0;
                end
            end
            default: begin
            end
        endcase
        res.address_low   = m_frame[SLOT_ADDR_LO];
        res.address_high  = m_frame[SLOT_ADDR_HI];
        res.frame_ready   = m_ready;
        res.bits_received = m_bits;
        return res;
    endfunction

    // Result check first, then the prediction for an event accepted at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: cmd %h ok %b addr %h/%h ready %b bits %0d",
                             o_out_data.command, o_out_data.command_ok,
                             o_out_data.address_low, o_out_data.address_high,
                             o_out_data.frame_ready, o_out_data.bits_received);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.command !== want.command
                        || o_out_data.command_ok !== want.command_ok
                        || o_out_data.address_low !== want.address_low
                        || o_out_data.address_high !== want.address_high
                        || o_out_data.frame_ready !== want.frame_ready
                        || o_out_data.bits_received !== want.bits_received) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected cmd %h ok %b addr %h/%h ready %b bits %0d",
                                 want.command, want.command_ok, want.address_low,
                                 want.address_high, want.frame_ready, want.bits_received);
                        $display("          got      cmd %h ok %b addr %h/%h ready %b bits %0d",
                                 o_out_data.command, o_out_data.command_ok,
                                 o_out_data.address_low, o_out_data.address_high,
                                 o_out_data.frame_ready, o_out_data.bits_received);
                    end
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pending_results.push_back(decode_event(i_in_data));
        end
    end

    function automatic logic [nir_pkg::TICK_W-1:0] rand_tick();
        int unsigned r;
        r = $urandom_range((1 << nir_pkg::TICK_W) - 1);
        return r[nir_pkg::TICK_W-1:0];
    endfunction

    // A tick count inside the window, or any count where the window is empty.
    function automatic logic [nir_pkg::TICK_W-1:0] tick_in(
        input logic [nir_pkg::TICK_W-1:0] lo,
        input logic [nir_pkg::TICK_W-1:0] hi
    );
        int unsigned l;
        int unsigned h;
        int unsigned r;
        l = lo;
        h = hi;
        if (h > l + 1) begin
            r = $urandom_range(h - 1, l + 1);
            return r[nir_pkg::TICK_W-1:0];
        end
        return rand_tick();
    endfunction

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Sends one event transaction, after a random idle gap, and waits for it
    // to be taken. Valid stays high afterwards for a back-to-back follower.
    task automatic send_event(input logic [nir_pkg::CMD_W-1:0] kind,
                              input logic [nir_pkg::TICK_W-1:0] ticks);
        nir_pkg::t_in_item ev;
        int unsigned       gap;
        ev.cmd      = kind;
        ev.interval = ticks;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes all six window registers; only called while the block is idle.
    task automatic load_windows(input nir_pkg::t_cfg w);
        logic [nir_pkg::REG_IDX_W-1:0] idx  [6];
        logic [nir_pkg::TICK_W-1:0]    vals [6];
        idx  = '{nir_pkg::REG_LEADER_LOW, nir_pkg::REG_LEADER_HIGH, nir_pkg::REG_ONE_LOW,
                 nir_pkg::REG_ONE_HIGH, nir_pkg::REG_ZERO_LOW, nir_pkg::REG_ZERO_HIGH};
        vals = '{w.leader_low, w.leader_high, w.one_low,
                 w.one_high, w.zero_low, w.zero_high};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        win = w;
    endtask

    // One frame: timeout, first edge, optional leader, the data bits LSB-first,
    // a closing timeout or edge, then a read.
    task automatic send_frame(input logic [31:0] word, input int unsigned n_bits,
                              input logic with_leader, input logic by_timeout);
        int unsigned b;
        send_event(nir_pkg::EV_TIMEOUT, rand_tick());
        send_event(nir_pkg::EV_EDGE, rand_tick());
        if (with_leader) begin
            send_event(nir_pkg::EV_EDGE, tick_in(win.leader_low, win.leader_high));
        end
        for (b = 0; b < n_bits; b++) begin
            if (word[b % nir_pkg::FRAME_BITS]) begin
                send_event(nir_pkg::EV_EDGE, tick_in(win.one_low, win.one_high));
            end else begin
                send_event(nir_pkg::EV_EDGE, tick_in(win.zero_low, win.zero_high));
            end
        end
        if (by_timeout) begin
            send_event(nir_pkg::EV_TIMEOUT, rand_tick());
        end else begin
            send_event(nir_pkg::EV_EDGE, rand_tick());
        end
        send_event(nir_pkg::EV_READ, rand_tick());
    endtask

    // Mostly well-formed frames with random content, mixed with broken frames and noise.
    task automatic run_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned code;
        logic [31:0] word;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            word = $urandom;
            if ($urandom_range(4) != 0) begin
                word[31:24] = ~word[23:16];
            end
            if (pick < 60) begin
                send_frame(word, nir_pkg::FRAME_BITS, 1'b1, 1'($urandom_range(1)));
            end else if (pick < 85) begin
                send_frame(word, $urandom_range(40), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end else begin
                code = $urandom_range(EV_UNUSED);
                send_event(code[nir_pkg::CMD_W-1:0], rand_tick());
            end
        end
    endtask

    // Window edges under the reset settings, the unused code and reads with
    // no frame ready.
    task automatic test_directed_events();
        set_idling(0, 0);
        send_event(nir_pkg::EV_READ, 11'd0);
        send_event(nir_pkg::EV_EDGE, 11'd2047);
        send_event(nir_pkg::EV_EDGE, 11'd190);
        send_event(nir_pkg::EV_EDGE, 11'd230);
        send_event(nir_pkg::EV_EDGE, 11'd35);
        send_event(nir_pkg::EV_EDGE, 11'd191);
        send_event(nir_pkg::EV_EDGE, 11'd30);
        send_event(nir_pkg::EV_EDGE, 11'd40);
        send_event(nir_pkg::EV_EDGE, 11'd31);
        send_event(nir_pkg::EV_EDGE, 11'd39);
        send_event(nir_pkg::EV_EDGE, 11'd14);
        send_event(nir_pkg::EV_EDGE, 11'd15);
        send_event(nir_pkg::EV_EDGE, 11'd21);
        send_event(nir_pkg::EV_EDGE, 11'd22);
        send_event(nir_pkg::EV_EDGE, 11'd229);
        send_event(EV_UNUSED, 11'd2047);
        send_event(nir_pkg::EV_EDGE, 11'd0);
        send_event(nir_pkg::EV_TIMEOUT, 11'd2047);
        send_event(nir_pkg::EV_READ, 11'd2047);
        send_event(nir_pkg::EV_EDGE, 11'd1234);
        send_event(EV_UNUSED, 11'd0);
        send_event(nir_pkg::EV_TIMEOUT, 11'd0);
        drain_results();
    endtask

    // Random traffic on the reset windows under each idling pattern.
    task automatic test_default_windows_traffic();
        int unsigned pat;
        int unsigned send_pcts [4];
        int unsigned recv_pcts [4];
        send_pcts = '{0, 76, 0, 21};
        recv_pcts = '{0, 0, 76, 21};
        for (pat = 0; pat < 4; pat++) begin
            set_idling(send_pcts[pat], recv_pcts[pat]);
            if (pat == 0) begin
                // A valid frame whose command is zero.
                send_frame({8'hFF, 8'h00, 16'($urandom)}, nir_pkg::FRAME_BITS, 1'b1, 1'b1);
            end
            run_traffic(40);
        end
        drain_results();
    endtask

    // The one and zero windows share ticks 31 to 39, so edges there store two
    // bits and the bit index can run past the frame.
    task automatic test_overlapping_windows();
        set_idling(21, 21);
        load_windows('{11'd100, 11'd300, 11'd20, 11'd40, 11'd30, 11'd50});
        run_traffic(35);
        drain_results();
    endtask

    // Widest windows, where every inner tick matches all three, then inverted
    // windows that match nothing.
    task automatic test_extreme_windows();
        set_idling(21, 21);
        load_windows('{11'd0, 11'd2047, 11'd0, 11'd2047, 11'd0, 11'd2047});
        run_traffic(25);
        drain_results();
        load_windows('{11'd2047, 11'd0, 11'd2047, 11'd0, 11'd2047, 11'd0});
        run_traffic(20);
        drain_results();
    endtask

    // Reset, the tests in turn, then the verdict.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_events();
        test_default_windows_traffic();
        test_overlapping_windows();
        test_extreme_windows();
        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/nir_pkg.sv
hw/rtl/nir_cfg_regs.sv
hw/rtl/nec_ir_frame_receiver.sv
tb/sv/nec_ir_frame_receiver_tb.sv
